// ----- hdl/tis_pkg.sv -----
package tis_pkg;

    // Default line buffer size
    localparam int LINE_LIMIT_DEF = 512;

    // Field and register widths
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // Decoupling queue between parser and beat emitter
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // TELNET command codes
    localparam logic [BYTE_W-1:0] C_SE     = 8'd240;
    localparam logic [BYTE_W-1:0] C_CMD_HI = 8'd249;
    localparam logic [BYTE_W-1:0] C_SB     = 8'd250;
    localparam logic [BYTE_W-1:0] C_WILL   = 8'd251;
    localparam logic [BYTE_W-1:0] C_DONT   = 8'd254;
    localparam logic [BYTE_W-1:0] C_IAC    = 8'd255;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STRIP   = 2'd0,
        CFG_STOP    = 2'd1,
        CFG_MAXLINE = 2'd2
    } t_cfg_idx;

    // Parser states, one-hot
    typedef enum logic [4:0] {
        P_DATA   = 5'b00001,
        P_IAC    = 5'b00010,
        P_OPT    = 5'b00100,
        P_SUB    = 5'b01000,
        P_SUBIAC = 5'b10000
    } t_pstate;

    // Live configuration seen by the parser
    typedef struct packed {
        logic              strip;
        logic [BYTE_W-1:0] stop;
        logic [LEN_W-1:0]  limit;
    } t_cfg;

    // One queued input: an optional pending 0xFF and an optional data byte
    typedef struct packed {
        logic              has_ff;
        logic              has_data;
        logic [BYTE_W-1:0] data;
        logic              line_end;
    } t_slot;

    // Queue status towards both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ----- hdl/tis_in_if.sv -----
interface tis_in_if;
    logic                          valid;
    logic                          ready;
    logic [tis_pkg::BYTE_W-1:0]    rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- hdl/tis_out_if.sv -----
interface tis_out_if;
    logic                          valid;
    logic                          ready;
    logic [tis_pkg::BYTE_W-1:0]    out_byte;
    logic                          line_end;
    logic                          last_for_input;

    modport source (output valid, output out_byte, output line_end, output last_for_input,
                    input ready);
    modport sink   (input valid, input out_byte, input line_end, input last_for_input,
                    output ready);
endinterface

// ----- hdl/tis_front.sv -----
module tis_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    tis_in_if.sink          i_in,
    input  tis_pkg::t_cfg   i_cfg,
    input  tis_pkg::t_q_stat i_q_stat,
    output logic            o_push,
    output tis_pkg::t_slot  o_slot
);

    tis_pkg::t_pstate                 r_state, n_state;
    logic [tis_pkg::LEN_W-1:0]        r_len, n_len;

    logic                             accept;
    logic [tis_pkg::BYTE_W-1:0]       c;
    logic                             room;
    logic                             has_ff;
    logic                             has_data;
    logic [tis_pkg::LEN_W-1:0]        base_len;
    logic [tis_pkg::LEN_W:0]          new_len;
    logic                             end_line;
    logic [tis_pkg::LEN_W:0]          lim_ext;

    // Accept whenever the queue has space
    assign i_in.ready = !i_q_stat.full;
    assign accept     = i_in.valid && i_in.ready;
    assign c          = i_in.rx_byte;
    assign lim_ext    = {1'b0, i_cfg.limit};

    // Room for a pending 0xFF without reaching the line end
    assign room = ({1'b0, r_len} + (tis_pkg::LEN_W+1)'(2)) < lim_ext;

    // Classify the byte against the parser state
    always_comb begin
        n_state  = r_state;
        has_ff   = 1'b0;
        has_data = 1'b0;
        if (!i_cfg.strip) begin
            has_data = 1'b1;
        end else begin
            unique case (r_state)
                tis_pkg::P_DATA: begin
                    if (c == tis_pkg::C_IAC) begin
                        n_state = tis_pkg::P_IAC;
                    end else begin
                        has_data = 1'b1;
                    end
                end
                tis_pkg::P_IAC: begin
                    n_state = tis_pkg::P_DATA;
                    unique case (c) inside
                        tis_pkg::C_SB:                   n_state = tis_pkg::P_SUB;
                        [tis_pkg::C_WILL:tis_pkg::C_DONT]: n_state = tis_pkg::P_OPT;
                        [tis_pkg::C_SE:tis_pkg::C_CMD_HI]: n_state = tis_pkg::P_DATA;
                        default: begin
                            has_ff   = room;
                            has_data = (c != tis_pkg::C_IAC);
                        end
                    endcase
                end
                tis_pkg::P_OPT: begin
                    n_state = tis_pkg::P_DATA;
                end
                tis_pkg::P_SUB: begin
                    if (c == tis_pkg::C_IAC) begin
                        n_state = tis_pkg::P_SUBIAC;
                    end
                end
                tis_pkg::P_SUBIAC: begin
                    if (c == tis_pkg::C_SE) begin
                        n_state = tis_pkg::P_DATA;
                    end else if (c != tis_pkg::C_IAC) begin
                        n_state = tis_pkg::P_SUB;
                    end
                end
                default: begin
                    n_state = tis_pkg::P_DATA;
                end
            endcase
        end
    end

    // Advance the line length past the pending 0xFF and the data byte
    assign base_len = has_ff ? (r_len + tis_pkg::LEN_W'(1)) : r_len;
    assign new_len  = {1'b0, base_len} + (tis_pkg::LEN_W+1)'(1);
    assign end_line = ((new_len + (tis_pkg::LEN_W+1)'(1)) >= lim_ext) || (c == i_cfg.stop);

    always_comb begin
        if (has_data) begin
            n_len = end_line ? '0 : new_len[tis_pkg::LEN_W-1:0];
        end else begin
            n_len = base_len;
        end
    end

    // Queue only bytes that give at least one beat
    assign o_push          = accept && (has_ff || has_data);
    assign o_slot.has_ff   = has_ff;
    assign o_slot.has_data = has_data;
    assign o_slot.data     = c;
    assign o_slot.line_end = end_line;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tis_pkg::P_DATA;
            r_len   <= '0;
        end else if (accept) begin
            r_state <= n_state;
            r_len   <= n_len;
        end
    end

endmodule

// ----- hdl/tis_queue.sv -----
module tis_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tis_pkg::t_slot   i_slot,
    input  logic             i_pop,
    output tis_pkg::t_slot   o_head,
    output tis_pkg::t_q_stat o_stat
);

    tis_pkg::t_slot                 r_mem [tis_pkg::Q_DEPTH];
    logic [tis_pkg::Q_PTR_W-1:0]    r_wr;
    logic [tis_pkg::Q_PTR_W-1:0]    r_rd;
    logic [tis_pkg::Q_CNT_W-1:0]    r_cnt;
    logic                           do_push;
    logic                           do_pop;

    assign o_stat.full  = (r_cnt == tis_pkg::Q_CNT_W'(tis_pkg::Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd];

    // Store the slot
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_slot;
        end
    end

    // Move the pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + tis_pkg::Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + tis_pkg::Q_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + tis_pkg::Q_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - tis_pkg::Q_CNT_W'(1);
            end
        end
    end

endmodule

// ----- hdl/tis_back.sv -----
module tis_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tis_pkg::t_slot   i_head,
    input  tis_pkg::t_q_stat i_q_stat,
    output logic             o_pop,
    tis_out_if.source        o_out
);

    logic                        r_valid;
    logic                        r_phase;
    logic [tis_pkg::BYTE_W-1:0]  r_byte;
    logic                        r_end;
    logic                        r_last;

    logic                        load;
    logic                        first_ff;

    // Load a new beat when the output register is free or being taken
    assign load     = (!r_valid || o_out.ready) && !i_q_stat.empty;
    assign first_ff = !r_phase && i_head.has_ff;
    assign o_pop    = load && !(first_ff && i_head.has_data);

    assign o_out.valid          = r_valid;
    assign o_out.out_byte       = r_byte;
    assign o_out.line_end       = r_end;
    assign o_out.last_for_input = r_last;

    // Control: valid flag and beat phase within a slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_phase <= first_ff && i_head.has_data;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload: pending 0xFF first, then the data byte
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= first_ff ? tis_pkg::C_IAC : i_head.data;
            r_end  <= first_ff ? 1'b0 : i_head.line_end;
            r_last <= first_ff ? !i_head.has_data : 1'b1;
        end
    end

endmodule

// ----- hdl/telnet_iac_strip_line_assembler.sv -----
// An accepted byte's result is written to the queue, then to the output
// register. One byte per cycle while the queue is not full; a byte with a
// pending 0xFF and a data byte gives two beats, held in a four-slot queue.
// Reset (synchronous, active low) sets the parser to data, the line length
// to zero, empties the queue and the output register, and loads the
// configuration defaults (strip on, stop byte 10, max line from LINE_LIMIT).
module telnet_iac_strip_line_assembler #(
    parameter int LINE_LIMIT = tis_pkg::LINE_LIMIT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tis_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tis_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    tis_in_if.sink                            i_in,
    tis_out_if.source                         o_out
);

    localparam int                       LimCapInt = (LINE_LIMIT > 1023) ? 1023 : LINE_LIMIT;
    localparam logic [tis_pkg::LEN_W-1:0] LimCap   = tis_pkg::LEN_W'(LimCapInt);

    logic                            r_strip;
    logic [tis_pkg::BYTE_W-1:0]      r_stop;
    logic [tis_pkg::LEN_W-1:0]       r_max_line;

    tis_pkg::t_cfg                   cfg;
    tis_pkg::t_slot                  push_slot;
    tis_pkg::t_slot                  head_slot;
    tis_pkg::t_q_stat                q_stat;
    logic                            push;
    logic                            pop;

    // Write the configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strip    <= 1'b1;
            r_stop     <= 8'd10;
            r_max_line <= LimCap;
        end else if (i_cfg_we) begin
            unique case (tis_pkg::t_cfg_idx'(i_cfg_idx))
                tis_pkg::CFG_STRIP:   r_strip    <= i_cfg_data[0];
                tis_pkg::CFG_STOP:    r_stop     <= i_cfg_data[tis_pkg::BYTE_W-1:0];
                tis_pkg::CFG_MAXLINE: r_max_line <= i_cfg_data[tis_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the line size to the build limit
    assign cfg.strip = r_strip;
    assign cfg.stop  = r_stop;
    assign cfg.limit = (r_max_line > LimCap) ? LimCap : r_max_line;

    tis_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (cfg),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_slot   (push_slot)
    );

    tis_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_slot  (push_slot),
        .i_pop   (pop),
        .o_head  (head_slot),
        .o_stat  (q_stat)
    );

    tis_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head_slot),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule

// ----- hdl/tis_chk.sv -----
module tis_chk (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [tis_pkg::BYTE_W-1:0]  i_out_byte,
    input  logic                        i_out_line_end,
    input  logic                        i_out_last
);

    // Output register empties on reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat shown straight after reset");

    // A line can only end on the final beat of a byte
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_line_end) |-> i_out_last)
        else $error("line end on a non-final beat");

    // A leading beat is always a pending 0xFF that never ends a line
    a_lead_ff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_last) |-> (i_out_byte == tis_pkg::C_IAC && !i_out_line_end))
        else $error("leading beat is not a plain 0xFF");

    // Hold a stalled beat
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_byte) && $stable(i_out_line_end)
             && $stable(i_out_last)))
        else $error("stalled result beat changed");

endmodule

bind telnet_iac_strip_line_assembler tis_chk u_tis_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_byte     (o_out.out_byte),
    .i_out_line_end (o_out.line_end),
    .i_out_last     (o_out.last_for_input)
);

// ----- bench/tis_line_checker.sv -----
module tis_line_checker #(
    parameter int LINE_LIMIT = tis_pkg::LINE_LIMIT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tis_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tis_pkg::CFG_DATA_W-1:0] i_cfg_data,
    tis_in_if                              i_in_mon,
    tis_out_if                             i_out_mon,
    output int                             o_mismatches,
    output int                             o_outstanding
);

    typedef struct packed {
        logic [tis_pkg::BYTE_W-1:0] data;
        logic                       line_end;
        logic                       last;
    } t_line_beat;

    // Shadow configuration and parser state
    logic                       strip_on;
    logic [tis_pkg::BYTE_W-1:0] stop_val;
    logic [tis_pkg::LEN_W-1:0]  max_line_reg;
    tis_pkg::t_pstate           parse_st;
    logic [tis_pkg::LEN_W-1:0]  line_len;

    t_line_beat expected_line_beats[$];
    int         mismatch_count = 0;

    function automatic int line_cap();
        return (int'(max_line_reg) > LINE_LIMIT) ? LINE_LIMIT : int'(max_line_reg);
    endfunction

    // Append one data byte to the line and predict its beat
    task automatic append_data(input logic [tis_pkg::BYTE_W-1:0] c);
        int         grown;
        logic       ends;
        t_line_beat beat;
        grown = int'(line_len) + 1;
        ends = (grown + 1 >= line_cap()) || (c == stop_val);
        beat.data = c;
        beat.line_end = ends;
        beat.last = 1'b1;
        expected_line_beats.push_back(beat);
        line_len = ends ? '0 : grown[tis_pkg::LEN_W-1:0];
    endtask

    // Advance the TELNET parser by one received byte
    task automatic strip_and_assemble(input logic [tis_pkg::BYTE_W-1:0] c);
        logic       take_data;
        t_line_beat beat;
        take_data = 1'b1;
        if (strip_on) begin
            case (parse_st)
                tis_pkg::P_IAC: begin
                    take_data = 1'b0;
                    if (c == tis_pkg::C_SB) begin
                        parse_st = tis_pkg::P_SUB;
                    end else if (c >= tis_pkg::C_WILL && c <= tis_pkg::C_DONT) begin
                        parse_st = tis_pkg::P_OPT;
                    end else if (c >= tis_pkg::C_SE && c <= tis_pkg::C_CMD_HI) begin
                        parse_st = tis_pkg::P_DATA;
                    end else begin
                        parse_st = tis_pkg::P_DATA;
                        // the pending 0xFF only goes out if it cannot end the line
                        if (int'(line_len) + 2 < line_cap()) begin
                            beat.data = tis_pkg::C_IAC;
                            beat.line_end = 1'b0;
                            beat.last = (c == tis_pkg::C_IAC);
                            expected_line_beats.push_back(beat);
                            line_len = line_len + 1'b1;
                        end
                        take_data = (c != tis_pkg::C_IAC);
                    end
                end
                tis_pkg::P_OPT: begin
                    parse_st = tis_pkg::P_DATA;
                    take_data = 1'b0;
                end
                tis_pkg::P_SUB: begin
                    if (c == tis_pkg::C_IAC) parse_st = tis_pkg::P_SUBIAC;
                    take_data = 1'b0;
                end
                tis_pkg::P_SUBIAC: begin
                    if (c == tis_pkg::C_SE) parse_st = tis_pkg::P_DATA;
                    else if (c != tis_pkg::C_IAC) parse_st = tis_pkg::P_SUB;
                    take_data = 1'b0;
                end
                default: begin
                    parse_st = tis_pkg::P_DATA;
                    if (c == tis_pkg::C_IAC) begin
                        parse_st = tis_pkg::P_IAC;
                        take_data = 1'b0;
                    end
                end
            endcase
        end
        if (take_data) append_data(c);
    endtask

    task automatic report_beat(input logic stray, input t_line_beat want, input t_line_beat got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            if (stray)
                $display("unexpected beat: byte %02h end %0b last %0b",
                         got.data, got.line_end, got.last);
            else
                $display({"mismatch: expected byte %02h end %0b last %0b, ",
                          "got byte %02h end %0b last %0b"},
                         want.data, want.line_end, want.last,
                         got.data, got.line_end, got.last);
        end
    endtask

    // Snoop configuration, check output beats, then predict from input beats
    always @(posedge i_clk) begin
        t_line_beat got;
        t_line_beat want;
        if (!i_rst_n) begin
            strip_on = 1'b1;
            stop_val = 8'd10;
            max_line_reg = (LINE_LIMIT > 1023) ? 10'd1023 : LINE_LIMIT[tis_pkg::LEN_W-1:0];
            parse_st = tis_pkg::P_DATA;
            line_len = '0;
            expected_line_beats.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tis_pkg::CFG_STRIP:   strip_on = i_cfg_data[0];
                    tis_pkg::CFG_STOP:    stop_val = i_cfg_data[tis_pkg::BYTE_W-1:0];
                    tis_pkg::CFG_MAXLINE: max_line_reg = i_cfg_data[tis_pkg::LEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.data = i_out_mon.out_byte;
                got.line_end = i_out_mon.line_end;
                got.last = i_out_mon.last_for_input;
                if (expected_line_beats.size() == 0) begin
                    report_beat(1'b1, got, got);
                end else begin
                    want = expected_line_beats.pop_front();
                    if (got !== want) report_beat(1'b0, want, got);
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) strip_and_assemble(i_in_mon.rx_byte);
        end
        o_mismatches <= mismatch_count;
        o_outstanding <= expected_line_beats.size();
    end

endmodule

// ----- bench/tb_telnet_iac_strip_line_assembler.sv -----
module tb_telnet_iac_strip_line_assembler;

    localparam int          CYCLE_LIMIT = 300000;
    localparam int          IDLE_PAD    = 6;
    localparam logic [7:0]  LF          = 8'd10;

    typedef enum {RDY_ALWAYS, RDY_RANDOM, RDY_ROTATE, RDY_SPARSE} t_sink_mode;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           cfg_we;
    tis_pkg::t_cfg_idx              cfg_idx;
    logic [tis_pkg::CFG_DATA_W-1:0] cfg_data;

    tis_in_if  in_bus();
    tis_out_if out_bus();

    int mismatch_total;
    int beats_owed;
    int cycle_count = 0;
    int burst_left = 0;
    int rx_sent = 0;
    logic [7:0] cur_stop = LF;
    logic [7:0] line_script[$];

    telnet_iac_strip_line_assembler uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_bus),
        .o_out      (out_bus)
    );

    tis_line_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_in_mon      (in_bus),
        .i_out_mon     (out_bus),
        .o_mismatches  (mismatch_total),
        .o_outstanding (beats_owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: hold each stall mode for a random stretch
    initial begin : sink_stall
        t_sink_mode mode;
        int         hold;
        logic [7:0] mask;
        out_bus.ready <= 1'b0;
        forever begin
            mode = t_sink_mode'($urandom_range(0, 3));
            hold = $urandom_range(20, 150);
            mask = 8'($urandom_range(1, 255));
            repeat (hold) begin
                @(posedge i_clk);
                case (mode)
                    RDY_ALWAYS: out_bus.ready <= 1'b1;
                    RDY_RANDOM: out_bus.ready <= ($urandom_range(0, 9) < 7);
                    RDY_ROTATE: begin
                        mask = {mask[6:0], mask[7]};
                        out_bus.ready <= mask[0];
                    end
                    default:    out_bus.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Send one byte, opening a new burst after a random gap when the last one ran out
    task automatic send_rx_beat(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        in_bus.valid <= 1'b1;
        in_bus.rx_byte <= b;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        burst_left--;
        rx_sent++;
    endtask

    task automatic play_script();
        foreach (line_script[i]) send_rx_beat(line_script[i]);
    endtask

    // Drop valid and wait for every predicted beat, then let the pipeline drain
    task automatic settle_idle();
        in_bus.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (beats_owed != 0) @(posedge i_clk);
        repeat (IDLE_PAD) @(posedge i_clk);
    endtask

    task automatic apply_setup(input logic strip, input logic [7:0] stop,
                               input logic [9:0] max_line);
        cfg_we <= 1'b1;
        cfg_idx <= tis_pkg::CFG_STRIP;
        cfg_data <= {{(tis_pkg::CFG_DATA_W-1){1'b0}}, strip};
        @(posedge i_clk);
        cfg_idx <= tis_pkg::CFG_STOP;
        cfg_data <= {{(tis_pkg::CFG_DATA_W-8){1'b0}}, stop};
        @(posedge i_clk);
        cfg_idx <= tis_pkg::CFG_MAXLINE;
        cfg_data <= max_line;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        cur_stop = stop;
    endtask

    // Mostly well-formed TELNET traffic with random content, some noise
    task automatic make_traffic(input int n);
        int target;
        int pick;
        int k;
        int r;
        target = rx_sent + n;
        while (rx_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                send_rx_beat(8'($urandom_range(0, 254)));
            end else if (pick < 55) begin
                send_rx_beat(cur_stop);
            end else if (pick < 65) begin
                send_rx_beat(tis_pkg::C_IAC);
                send_rx_beat(8'($urandom_range(tis_pkg::C_WILL, tis_pkg::C_DONT)));
                send_rx_beat(8'($urandom_range(0, 255)));
            end else if (pick < 73) begin
                send_rx_beat(tis_pkg::C_IAC);
                send_rx_beat(8'($urandom_range(tis_pkg::C_SE, tis_pkg::C_CMD_HI)));
            end else if (pick < 80) begin
                send_rx_beat(tis_pkg::C_IAC);
                send_rx_beat(tis_pkg::C_IAC);
            end else if (pick < 85) begin
                send_rx_beat(tis_pkg::C_IAC);
                send_rx_beat(8'($urandom_range(0, tis_pkg::C_SE - 1)));
            end else if (pick < 93) begin
                send_rx_beat(tis_pkg::C_IAC);
                send_rx_beat(tis_pkg::C_SB);
                k = $urandom_range(0, 5);
                repeat (k) begin
                    r = $urandom_range(0, 9);
                    if (r == 0) begin
                        send_rx_beat(tis_pkg::C_IAC);
                        send_rx_beat(tis_pkg::C_IAC);
                    end else if (r == 1) begin
                        send_rx_beat(tis_pkg::C_IAC);
                        send_rx_beat(8'($urandom_range(0, tis_pkg::C_SE - 1)));
                    end else begin
                        send_rx_beat(8'($urandom_range(0, 254)));
                    end
                end
                send_rx_beat(tis_pkg::C_IAC);
                send_rx_beat(tis_pkg::C_SE);
            end else begin
                send_rx_beat(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin : stimulus
        i_rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_idx <= tis_pkg::CFG_STRIP;
        cfg_data <= '0;
        in_bus.valid <= 1'b0;
        in_bus.rx_byte <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Defaults: every command form, escaped IAC, pending IAC, stop byte
        line_script = '{8'h41, 8'h00, 8'hFE, tis_pkg::C_IAC, tis_pkg::C_IAC,
                        tis_pkg::C_IAC, tis_pkg::C_WILL, 8'h01,
                        tis_pkg::C_IAC, tis_pkg::C_SE, tis_pkg::C_IAC, tis_pkg::C_CMD_HI,
                        tis_pkg::C_IAC, tis_pkg::C_SB, 8'h18, tis_pkg::C_IAC,
                        tis_pkg::C_IAC, 8'h7F, tis_pkg::C_IAC, tis_pkg::C_SE,
                        tis_pkg::C_IAC, 8'h51, LF};
        play_script();
        make_traffic(100);
        settle_idle();

        // Tiny line: pending IAC without room is dropped, long line cut short
        apply_setup(1'b1, 8'h00, 10'd4);
        line_script = '{8'h61, 8'h62, tis_pkg::C_IAC, 8'h63};
        play_script();
        make_traffic(70);
        settle_idle();

        // Stripping off at the smallest legal size, 0xFF as stop byte
        apply_setup(1'b0, 8'hFF, 10'd2);
        line_script = '{8'hFF, 8'h00};
        play_script();
        make_traffic(60);
        settle_idle();

        // Size above the buffer limit, escaped IAC as stop byte
        apply_setup(1'b1, 8'hFF, 10'd1023);
        make_traffic(70);
        settle_idle();

        // Size below the legal range with stripping off
        apply_setup(1'b0, LF, 10'd1);
        make_traffic(40);
        settle_idle();

        apply_setup(1'b1, 8'h0D, 10'd20);
        make_traffic(100);
        settle_idle();

        apply_setup(1'b1, LF, 10'd512);
        make_traffic(100);
        settle_idle();

        repeat (10) @(posedge i_clk);
        if (mismatch_total == 0 && beats_owed == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
